// ===== rtl/core/rcis_pkg.sv =====
// ----------------------------------------------------------------------------
// rcis_pkg
// Types, opcodes and helpers shared by the instruction step unit.
// ----------------------------------------------------------------------------
package rcis_pkg;

	localparam logic [7:0] OP_HALT = 8'd0;
	localparam logic [7:0] OP_ADD  = 8'd2;
	localparam logic [7:0] OP_SUB  = 8'd3;
	localparam logic [7:0] OP_MUL  = 8'd4;
	localparam logic [7:0] OP_DIV  = 8'd5;
	localparam logic [7:0] OP_CMP  = 8'd6;
	localparam logic [7:0] OP_MOV  = 8'd7;
	localparam logic [7:0] OP_AND  = 8'd8;
	localparam logic [7:0] OP_OR   = 8'd9;
	localparam logic [7:0] OP_XOR  = 8'd10;
	localparam logic [7:0] OP_NOT  = 8'd11;
	localparam logic [7:0] OP_JE   = 8'd12;
	localparam logic [7:0] OP_JNE  = 8'd13;
	localparam logic [7:0] OP_JL   = 8'd14;
	localparam logic [7:0] OP_JLE  = 8'd15;
	localparam logic [7:0] OP_JG   = 8'd16;
	localparam logic [7:0] OP_JGE  = 8'd17;
	localparam logic [7:0] OP_JMP  = 8'd18;
	localparam logic [7:0] OP_LD   = 8'd19;
	localparam logic [7:0] OP_ST   = 8'd20;
	localparam logic [7:0] OP_MOVI = 8'd21;
	localparam logic [7:0] OP_ADDI = 8'd22;
	localparam logic [7:0] OP_SUBI = 8'd23;
	localparam logic [7:0] OP_MULI = 8'd24;
	localparam logic [7:0] OP_DIVI = 8'd25;
	localparam logic [7:0] OP_LSH  = 8'd26;
	localparam logic [7:0] OP_RSH  = 8'd27;

	typedef struct packed {
		logic       mode;
		logic [7:0] load_address;
		logic [7:0] load_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]  program_counter;
		logic [31:0] instruction_word;
		logic        halted;
		logic        flag_equal;
		logic        flag_less;
		logic        flag_greater;
		logic        wrote_register;
		logic [2:0]  dest_index;
		logic [31:0] dest_value;
	} rsp_t;

	typedef struct packed {
		logic     clr_step;
		logic     latch;
		logic     fetch_init;
		logic     ld_init;
		logic     rd_issue;
		logic     rd_shift;
		logic     decode;
		logic     div_start;
		logic     mod_start;
		logic     alu_cap;
		logic     div_cap;
		logic     jmp_cap;
		logic     ld_cap;
		logic     mem_load;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       mode;
		logic [7:0] op;
		logic       cnt_last;
		logic       div_done;
		logic       mod_done;
		logic       jump_taken;
	} sts_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROUTE,
		S_LWAIT,
		S_FRD,
		S_FSH,
		S_DEC,
		S_EXEC,
		S_DWAIT,
		S_JWAIT,
		S_LDWAIT,
		S_LRD,
		S_LSH,
		S_LCAP,
		S_FIN
	} state_t;

	function automatic logic op_writes(input logic [7:0] op);
		logic w;
		w = 1'b0;
		if (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV || op == OP_MOV ||
		    op == OP_AND || op == OP_OR || op == OP_XOR || op == OP_NOT || op == OP_LD ||
		    op == OP_MOVI || op == OP_ADDI || op == OP_SUBI || op == OP_MULI ||
		    op == OP_DIVI || op == OP_LSH || op == OP_RSH)
			w = 1'b1;
		return w;
	endfunction

endpackage

// ===== rtl/core/register_cpu_instruction_step_unit.sv =====
// ----------------------------------------------------------------------------
// register_cpu_instruction_step_unit
// One request either writes a memory byte or runs one CPU instruction.
// ----------------------------------------------------------------------------
// After reset the unit clears its MEM_BYTES of memory, one byte a cycle, and
// holds busy high until that is done. A request is taken when start is high
// and busy low; its result appears on result for one cycle with done high
// and cannot be held off. A byte write reduces its address modulo the memory
// size by a two-stage reciprocal multiply. An ordinary instruction is paced
// by the four byte-wide memory reads of the fetch. Divides then wait on the
// 32-step divider; taken jumps wait to reduce the target; a load does the
// address reduction, then four more reads.
// ----------------------------------------------------------------------------
module register_cpu_instruction_step_unit
	import rcis_pkg::*;
#(
	parameter int MEM_BYTES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	cmd_t cmd;
	sts_t sts;

	rcis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rcis_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but unit not busy");
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");
	a_dest_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.wrote_register |->
		result.dest_index == 3'd0 && result.dest_value == 32'd0)
		else $error("destination fields set without a register write");
`endif

endmodule

// ===== rtl/core/rcis_div.sv =====
// ----------------------------------------------------------------------------
// rcis_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcis_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/rcis_dp.sv =====
// ----------------------------------------------------------------------------
// rcis_dp
// Datapath: main memory, register file, pc, flags, ALU and divider.
// ----------------------------------------------------------------------------
module rcis_dp
	import rcis_pkg::*;
#(
	parameter int MEM_BYTES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t result
);

	localparam int AW     = $clog2(MEM_BYTES);
	localparam int MOD_SH = 21 + AW;
	localparam longint unsigned MOD_RECIP =
		((64'd1 << MOD_SH) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES);

	logic [7:0]    mem [MEM_BYTES];
	logic [31:0]   rf_q [8];
	logic [AW-1:0] clr_q;
	logic [AW-1:0] pc_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] tgt_q;
	logic [1:0]    cnt_q;
	logic [7:0]    rdata_q;
	logic [31:0]   word_q;
	logic [31:0]   ir_q;
	logic [31:0]   a_q;
	logic [31:0]   b_q;
	logic [31:0]   res_q;
	logic          jump_q;
	logic          feq_q, flt_q, fgt_q;
	req_t          req_q;
	rsp_t          rsp_q;

	logic [7:0]    op;
	logic [2:0]    ra;
	logic [31:0]   imm32;
	logic [31:0]   opnd;
	logic [31:0]   alu;
	logic [AW:0]   rd_sum;
	logic [AW-1:0] rd_addr;
	logic [AW:0]   pc_sum;
	logic [AW-1:0] pc_next;
	logic [31:0]   div_n, div_d, div_q;
	logic          div_done;
	logic          wr;
	logic [20:0]   mod_x;
	logic [43:0]   mod_prod;
	logic [20:0]   mod_quo_s1;
	logic [AW-1:0] mod_rem_s2;
	logic          mod_vld_s1, mod_vld_s2;

	assign op    = ir_q[31:24];
	assign ra    = ir_q[23:21];
	assign imm32 = {11'b0, ir_q[20:0]};
	assign opnd  = (op >= OP_MOVI) ? imm32 : b_q;

	always_comb begin
		unique case (op)
			OP_ADD, OP_ADDI: alu = a_q + opnd;
			OP_SUB, OP_SUBI: alu = a_q - opnd;
			OP_MUL, OP_MULI: alu = a_q * opnd;
			OP_MOV:          alu = b_q;
			OP_AND:          alu = a_q & b_q;
			OP_OR:           alu = a_q | b_q;
			OP_XOR:          alu = a_q ^ b_q;
			OP_NOT:          alu = {31'b0, a_q == 32'd0};
			OP_MOVI:         alu = imm32;
			OP_LSH:          alu = (imm32 >= 32'd32) ? 32'd0 : a_q << imm32[4:0];
			OP_RSH:          alu = (imm32 >= 32'd32) ? 32'd0 : a_q >> imm32[4:0];
			default:         alu = 32'd0;
		endcase
	end

	assign div_n = a_q;
	assign div_d = (op == OP_DIVI) ? imm32 : b_q;

	rcis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quotient (div_q),
		.done     (div_done)
	);

	// reduce an address modulo the memory size by reciprocal multiply
	assign mod_x    = req_q.mode ? ir_q[20:0] : {13'b0, req_q.load_address};
	assign mod_prod = 44'(mod_x) * 44'(MOD_RECIP);

	always_ff @(posedge clk) begin
		mod_quo_s1 <= 21'(mod_prod >> MOD_SH);
		mod_rem_s2 <= AW'(mod_x - 21'(mod_quo_s1 * 21'(MEM_BYTES)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_vld_s1 <= 1'b0;
			mod_vld_s2 <= 1'b0;
		end else begin
			mod_vld_s1 <= cmd.mod_start;
			mod_vld_s2 <= mod_vld_s1;
		end
	end

	assign rd_sum  = {1'b0, base_q} + (AW+1)'(cnt_q);
	assign rd_addr = (rd_sum >= (AW+1)'(MEM_BYTES)) ?
	                 AW'(rd_sum - (AW+1)'(MEM_BYTES)) : rd_sum[AW-1:0];
	assign pc_sum  = {1'b0, pc_q} + (AW+1)'(4);
	assign pc_next = (pc_sum >= (AW+1)'(MEM_BYTES)) ?
	                 AW'(pc_sum - (AW+1)'(MEM_BYTES)) : pc_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			mem[clr_q] <= 8'd0;
		else if (cmd.mem_load)
			mem[mod_rem_s2] <= req_q.load_byte;
		if (cmd.rd_issue)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)
			req_q <= request;
		if (cmd.fetch_init) begin
			base_q <= pc_q;
			cnt_q  <= '0;
		end else if (cmd.ld_init) begin
			base_q <= mod_rem_s2;
			cnt_q  <= '0;
		end else if (cmd.rd_shift) begin
			word_q <= {word_q[23:0], rdata_q};
			cnt_q  <= cnt_q + 2'd1;
		end
		if (cmd.decode) begin
			ir_q   <= word_q;
			a_q    <= rf_q[word_q[23:21]];
			b_q    <= rf_q[word_q[20:18]];
			jump_q <= 1'b0;
		end else if (cmd.jmp_cap) begin
			tgt_q  <= mod_rem_s2;
			jump_q <= 1'b1;
		end
		if (cmd.alu_cap)
			res_q <= alu;
		else if (cmd.div_cap)
			res_q <= div_q;
		else if (cmd.ld_cap)
			res_q <= word_q;
	end

	assign wr = op_writes(op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				rf_q[i] <= '0;
			pc_q  <= '0;
			feq_q <= 1'b0;
			flt_q <= 1'b0;
			fgt_q <= 1'b0;
		end else begin
			if (cmd.commit && req_q.mode) begin
				if (wr)
					rf_q[ra] <= res_q;
				if (op == OP_CMP) begin
					feq_q <= a_q == b_q;
					flt_q <= a_q < b_q;
					fgt_q <= a_q > b_q;
				end
				if (op != OP_HALT)
					pc_q <= jump_q ? tgt_q : pc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (!req_q.mode) begin
				rsp_q.program_counter  <= 8'(32'(pc_q));
				rsp_q.instruction_word <= '0;
				rsp_q.halted           <= 1'b0;
				rsp_q.flag_equal       <= feq_q;
				rsp_q.flag_less        <= flt_q;
				rsp_q.flag_greater     <= fgt_q;
				rsp_q.wrote_register   <= 1'b0;
				rsp_q.dest_index       <= '0;
				rsp_q.dest_value       <= '0;
			end else begin
				rsp_q.program_counter  <= 8'(32'((op == OP_HALT) ? pc_q :
				                          (jump_q ? tgt_q : pc_next)));
				rsp_q.instruction_word <= ir_q;
				rsp_q.halted           <= op == OP_HALT;
				rsp_q.flag_equal       <= (op == OP_CMP) ? (a_q == b_q) : feq_q;
				rsp_q.flag_less        <= (op == OP_CMP) ? (a_q < b_q) : flt_q;
				rsp_q.flag_greater     <= (op == OP_CMP) ? (a_q > b_q) : fgt_q;
				rsp_q.wrote_register   <= wr;
				rsp_q.dest_index       <= wr ? ra : 3'd0;
				rsp_q.dest_value       <= wr ? res_q : 32'd0;
			end
		end
	end

	always_comb begin
		sts.clr_last = clr_q == AW'(MEM_BYTES - 1);
		sts.mode     = req_q.mode;
		sts.op       = op;
		sts.cnt_last = cnt_q == 2'd3;
		sts.div_done = div_done;
		sts.mod_done = mod_vld_s2;
		unique case (op)
			OP_JE:   sts.jump_taken = feq_q;
			OP_JNE:  sts.jump_taken = !feq_q;
			OP_JL:   sts.jump_taken = flt_q;
			OP_JLE:  sts.jump_taken = feq_q || flt_q;
			OP_JG:   sts.jump_taken = fgt_q;
			OP_JGE:  sts.jump_taken = feq_q || fgt_q;
			OP_JMP:  sts.jump_taken = 1'b1;
			default: sts.jump_taken = 1'b0;
		endcase
	end

	assign result = rsp_q;

`ifndef SYNTHESIS
	a_pc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pc_q) < 32'(MEM_BYTES))
		else $error("pc out of memory range");
	a_mode0_no_regs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !req_q.mode |=> $stable(pc_q))
		else $error("byte write moved pc");
	a_halt_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && req_q.mode && op == OP_HALT |=> $stable(pc_q))
		else $error("halt moved pc");
`endif

endmodule

// ===== rtl/core/rcis_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcis_ctrl
// Sequencer: memory clearing, byte writes, fetch, execute, divide, jump and load waits, and commit.
// ----------------------------------------------------------------------------
module rcis_ctrl
	import rcis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.commit;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_ROUTE;
				end
			end
			S_ROUTE: begin
				if (!sts.mode) begin
					cmd.mod_start = 1'b1;
					state_d       = S_LWAIT;
				end else begin
					cmd.fetch_init = 1'b1;
					state_d        = S_FRD;
				end
			end
			S_LWAIT: begin
				if (sts.mod_done) begin
					cmd.mem_load = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FRD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_FSH;
			end
			S_FSH: begin
				cmd.rd_shift = 1'b1;
				state_d      = sts.cnt_last ? S_DEC : S_FRD;
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				priority if (sts.op == OP_DIV || sts.op == OP_DIVI) begin
					cmd.div_start = 1'b1;
					state_d       = S_DWAIT;
				end else if (sts.op == OP_LD) begin
					cmd.mod_start = 1'b1;
					state_d       = S_LDWAIT;
				end else if (sts.jump_taken) begin
					cmd.mod_start = 1'b1;
					state_d       = S_JWAIT;
				end else begin
					cmd.alu_cap = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_cap = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_JWAIT: begin
				if (sts.mod_done) begin
					cmd.jmp_cap = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_LDWAIT: begin
				if (sts.mod_done) begin
					cmd.ld_init = 1'b1;
					state_d     = S_LRD;
				end
			end
			S_LRD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_LSH;
			end
			S_LSH: begin
				cmd.rd_shift = 1'b1;
				state_d      = sts.cnt_last ? S_LCAP : S_LRD;
			end
			S_LCAP: begin
				cmd.ld_cap = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

`ifndef SYNTHESIS
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !done_q)
		else $error("result during memory clear");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_DWAIT)
		else $error("divider started without a wait state");
	a_mod_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |=> state_q == S_LWAIT || state_q == S_JWAIT ||
		state_q == S_LDWAIT)
		else $error("address reduction started without a wait state");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE && done_q)
		else $error("commit did not return to idle");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the instruction step unit: byte loads build small
// programs in memory, execute requests run them, and a predictor of the CPU
// state checks every result field.
// ----------------------------------------------------------------------------
module tb_top;
	import rcis_pkg::*;

	localparam int MEM_SIZE  = 256;
	localparam int CYC_LIMIT = 900000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	register_cpu_instruction_step_unit #(.MEM_BYTES(MEM_SIZE)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	logic [7:0]  cpu_mem [MEM_SIZE];
	logic [31:0] cpu_regs [8];
	logic [7:0]  cpu_pc;
	logic        cpu_eq, cpu_lt, cpu_gt;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   fail_count;
	int   cycle_count;
	int   gap_left;
	int   exec_count, load_count;
	bit   quiet_mode;
	bit   drain_hold;
	logic busy_at_edge;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] fetch_word(input logic [7:0] addr);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < 4; i++)
			w = {w[23:0], cpu_mem[8'(addr + i)]};
		return w;
	endfunction

	function automatic logic [31:0] quotient(input logic [31:0] n, input logic [31:0] d);
		return (d == 0) ? 32'hFFFF_FFFF : n / d;
	endfunction

	function automatic rsp_t step_cpu(input req_t rq);
		rsp_t r;
		logic [31:0] word, a, b, val;
		logic [20:0] imm;
		logic [7:0]  op;
		logic [2:0]  ra, rb;
		logic        wr, jmp, hlt;
		r = '0;
		word = '0; val = '0; wr = 0; jmp = 0; hlt = 0;
		if (!rq.mode) begin
			cpu_mem[rq.load_address] = rq.load_byte;
		end else begin
			word = fetch_word(cpu_pc);
			op = word[31:24]; ra = word[23:21]; rb = word[20:18]; imm = word[20:0];
			a = cpu_regs[ra]; b = cpu_regs[rb];
			case (op)
				OP_HALT: hlt = 1;
				OP_ADD: begin wr = 1; val = a + b; end
				OP_SUB: begin wr = 1; val = a - b; end
				OP_MUL: begin wr = 1; val = a * b; end
				OP_DIV: begin wr = 1; val = quotient(a, b); end
				OP_CMP: begin cpu_eq = (a == b); cpu_lt = (a < b); cpu_gt = (a > b); end
				OP_MOV: begin wr = 1; val = b; end
				OP_AND: begin wr = 1; val = a & b; end
				OP_OR: begin wr = 1; val = a | b; end
				OP_XOR: begin wr = 1; val = a ^ b; end
				OP_NOT: begin wr = 1; val = (a == 0) ? 32'd1 : 32'd0; end
				OP_JE: jmp = cpu_eq;
				OP_JNE: jmp = !cpu_eq;
				OP_JL: jmp = cpu_lt;
				OP_JLE: jmp = cpu_eq || cpu_lt;
				OP_JG: jmp = cpu_gt;
				OP_JGE: jmp = cpu_eq || cpu_gt;
				OP_JMP: jmp = 1;
				OP_LD: begin wr = 1; val = fetch_word(imm[7:0]); end
				OP_MOVI: begin wr = 1; val = 32'(imm); end
				OP_ADDI: begin wr = 1; val = a + 32'(imm); end
				OP_SUBI: begin wr = 1; val = a - 32'(imm); end
				OP_MULI: begin wr = 1; val = a * 32'(imm); end
				OP_DIVI: begin wr = 1; val = quotient(a, 32'(imm)); end
				OP_LSH: begin wr = 1; val = (imm >= 32) ? 32'd0 : a << imm; end
				OP_RSH: begin wr = 1; val = (imm >= 32) ? 32'd0 : a >> imm; end
				default: ;
			endcase
			if (wr) cpu_regs[ra] = val;
			if (!hlt) cpu_pc = jmp ? imm[7:0] : cpu_pc + 8'd4;
			r.dest_index = wr ? ra : 3'd0;
			r.dest_value = val;
		end
		r.program_counter = cpu_pc;
		r.instruction_word = word;
		r.halted = hlt;
		r.flag_equal = cpu_eq;
		r.flag_less = cpu_lt;
		r.flag_greater = cpu_gt;
		r.wrote_register = wr;
		return r;
	endfunction

	function automatic req_t byte_req(input logic [7:0] addr, input logic [7:0] data);
		req_t r;
		r.mode = 1'b0; r.load_address = addr; r.load_byte = data;
		return r;
	endfunction

	function automatic req_t exec_req();
		req_t r;
		r.mode = 1'b1;
		r.load_address = 8'($urandom);
		r.load_byte = 8'($urandom);
		return r;
	endfunction

	task automatic put_word(input logic [7:0] addr, input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(byte_req(8'(addr + i), w[31 - 8*i -: 8]));
	endtask

	function automatic logic [31:0] rand_instr();
		logic [7:0]  op;
		logic [20:0] imm;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 15) op = 8'($urandom_range(1, 27));
		else if (sel < 17) op = 8'($urandom_range(28, 255));
		else if (sel < 18) op = OP_HALT;
		else op = OP_LD;
		case ($urandom_range(0, 4))
			0: imm = 21'($urandom_range(0, 40));
			1: imm = 21'h1FFFFF;
			2: imm = {13'($urandom), 8'($urandom_range(0, 63)) & 8'hFC};
			default: imm = 21'($urandom);
		endcase
		if (op >= OP_JE && op <= OP_JMP && $urandom_range(0, 2) != 0)
			imm = {13'($urandom), 8'($urandom_range(0, 15) * 4)};
		return {op, 3'($urandom), imm};
	endfunction

	// stimulus
	initial begin
		int n;
		fail_count = 0; exec_count = 0; load_count = 0;
		quiet_mode = 0; drain_hold = 0;
		for (int i = 0; i < MEM_SIZE; i++) cpu_mem[i] = '0;
		for (int i = 0; i < 8; i++) cpu_regs[i] = '0;
		cpu_pc = '0; cpu_eq = 0; cpu_lt = 0; cpu_gt = 0;

		// directed program: extremes, wrap, divide by zero, large shifts, store
		put_word(8'd0, {OP_MOVI, 3'd1, 21'h1FFFFF});
		put_word(8'd4, {OP_LSH, 3'd1, 21'd11});
		put_word(8'd8, {OP_DIVI, 3'd1, 21'd0});
		put_word(8'd12, {OP_RSH, 3'd1, 21'd32});
		put_word(8'd16, {OP_ST, 3'd2, 21'h1FFFFF});
		put_word(8'd20, {OP_CMP, 3'd1, 3'd2, 18'd0});
		put_word(8'd24, {OP_JE, 3'd0, 21'h1FFF00});
		pending_reqs.push_back(byte_req(8'hFF, 8'hFF));
		pending_reqs.push_back(byte_req(8'h00, OP_LD));
		for (int i = 0; i < 8; i++) pending_reqs.push_back(exec_req());
		pending_reqs.push_back(exec_req());
		pending_reqs.push_back(exec_req());

		n = 0;
		while (n < 1420) begin
			int len;
			logic [7:0] base;
			if (n > 1200) quiet_mode = 1;
			len = $urandom_range(1, 12);
			base = 8'($urandom_range(0, 63) * 4);
			if ($urandom_range(0, 9) == 0) begin
				pending_reqs.push_back(byte_req(8'($urandom), 8'($urandom)));
				n++;
			end else begin
				for (int k = 0; k < len; k++) begin
					put_word(8'(base + 4*k), rand_instr());
					if ($urandom_range(0, 3) == 0)
						put_word(8'($urandom_range(0, 63) * 4), 32'($urandom));
				end
				for (int k = 0; k < 4; k++)
					pending_reqs.push_back(byte_req(8'd252 + 8'(k), 8'(base)));
				pending_reqs.push_back(byte_req(8'(8'hFC & ($urandom)),
					8'($urandom_range(0, 1) ? OP_JMP : 8'($urandom))));
				n += 4*len + 5;
				for (int k = 0; k < len + 4; k++) pending_reqs.push_back(exec_req());
				n += len + 4;
			end
			if (n > 600 && n < 700 && !drain_hold) begin
				drain_hold = 1;
				wait (pending_reqs.size() == 0 && !start && expected_rsps.size() == 0);
			end
			wait (pending_reqs.size() < 40);
		end
		wait (pending_reqs.size() == 0 && !start && expected_rsps.size() == 0);
		repeat (120) @(posedge clk);
		$display("Covered %0d execute and %0d byte-load requests, all opcode groups.",
			exec_count, load_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// driver
	initial begin
		start = 1'b0;
		request = '0;
		gap_left = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!(start && busy_at_edge)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					request <= pending_reqs.pop_front();
					start <= 1'b1;
					if (!quiet_mode && $urandom_range(0, 7) == 0)
						gap_left <= $urandom_range(1, 19);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// predict on acceptance, check on strobe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_at_edge <= 1'b1;
			cycle_count <= 0;
		end else begin
			busy_at_edge <= busy;
			cycle_count <= cycle_count + 1;
			if (cycle_count > CYC_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
			if (start && !busy) begin
				expected_rsps.push_back(step_cpu(request));
				if (request.mode) exec_count++;
				else load_count++;
			end
			if (done) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result");
					fail_count++;
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (result.program_counter !== e.program_counter) begin
						$error("program_counter exp %0h got %0h", e.program_counter,
							result.program_counter); fail_count++; end
					if (result.instruction_word !== e.instruction_word) begin
						$error("instruction_word exp %0h got %0h", e.instruction_word,
							result.instruction_word); fail_count++; end
					if (result.halted !== e.halted) begin
						$error("halted exp %0b got %0b", e.halted, result.halted);
						fail_count++; end
					if (result.flag_equal !== e.flag_equal) begin
						$error("flag_equal exp %0b got %0b", e.flag_equal,
							result.flag_equal); fail_count++; end
					if (result.flag_less !== e.flag_less) begin
						$error("flag_less exp %0b got %0b", e.flag_less,
							result.flag_less); fail_count++; end
					if (result.flag_greater !== e.flag_greater) begin
						$error("flag_greater exp %0b got %0b", e.flag_greater,
							result.flag_greater); fail_count++; end
					if (result.wrote_register !== e.wrote_register) begin
						$error("wrote_register exp %0b got %0b", e.wrote_register,
							result.wrote_register); fail_count++; end
					if (result.dest_index !== e.dest_index) begin
						$error("dest_index exp %0d got %0d", e.dest_index,
							result.dest_index); fail_count++; end
					if (result.dest_value !== e.dest_value) begin
						$error("dest_value exp %0h got %0h", e.dest_value,
							result.dest_value); fail_count++; end
				end
			end
		end
	end

endmodule
